// ===== hdl/u8rx_pkg.sv =====
package u8rx_pkg;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] BIT_PERIOD_RESET = 16'd729;
    localparam logic [3:0] DATA_BITS = 4'd8;

    localparam int unsigned IN_W = 8;
    localparam int unsigned OUT_W = 24;
    localparam int unsigned FILL_W = 6;

    // one tick's receiver outcome, handed from the front to the fifo side
    typedef struct packed {
        logic       pop_req;
        logic       store;
        logic [7:0] data;
        logic       busy;
        logic       glitch;
    } rx_event_t;

endpackage

// ===== hdl/uart_8n1_receiver_with_fifo_core.sv =====
// channel   | dir | handshake           | payload
// s_        | in  | s_tvalid/s_tready   | s_tdata: rx_level, pop_req
// m_        | out | m_tvalid/m_tready   | m_tdata: pop_data .. byte_dropped
// cfg_      | in  | cfg_valid/cfg_ready | cfg_data: bit_period
//
// one tick word per clock sustained while m_tready stays high; the receiver counter steps once per accepted word
// a result is registered in the two-entry queue and then in the output register before it appears on m_
// a two-entry queue and the output register absorb m_ stalls; s_tready drops when the queue fills
// aresetn is synchronous; the fifo storage itself is not cleared, only its pointers
// s_tready and cfg_ready stay low while aresetn is held
module uart_8n1_receiver_with_fifo_core #(
    parameter int unsigned FIFO_DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8rx_pkg::IN_W-1:0]          s_tdata,   // [0] rx_level, [1] pop_req
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] pop_data, [8] pop_valid, [14:9] fill_count, [15] frame_busy,
    // [16] start_glitch, [17] byte_dropped
    output logic [u8rx_pkg::OUT_W-1:0]         m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [u8rx_pkg::CNT_W-1:0]         cfg_data
);

    u8rx_pkg::rx_event_t front_ev;
    u8rx_pkg::rx_event_t back_ev;
    logic                front_push;
    logic                q_ready;
    logic                q_valid;
    logic                back_take;

    assign s_tready  = q_ready & aresetn;
    assign cfg_ready = aresetn;

    u8rx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .q_ready   (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ev_push   (front_push),
        .ev        (front_ev)
    );

    u8rx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_data  (front_ev),
        .push_ready (q_ready),
        .pop        (back_take),
        .pop_valid  (q_valid),
        .pop_data   (back_ev)
    );

    u8rx_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev_valid (q_valid),
        .ev       (back_ev),
        .ev_take  (back_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/u8rx_front.sv =====
module u8rx_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                q_ready,
    input  logic [u8rx_pkg::IN_W-1:0]           s_tdata,
    input  logic                                cfg_valid,
    input  logic [u8rx_pkg::CNT_W-1:0]          cfg_data,
    output logic                                ev_push,
    output u8rx_pkg::rx_event_t                 ev
);

    logic [u8rx_pkg::CNT_W-1:0] bit_period_reg;
    logic                       prev_level_reg, prev_level_next;
    logic                       recv_reg, recv_next;
    logic [3:0]                 bits_reg, bits_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [u8rx_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [u8rx_pkg::CNT_W-1:0] tgt_reg, tgt_next;
    logic [u8rx_pkg::CNT_W-1:0] full_iv;
    logic [u8rx_pkg::CNT_W-1:0] half_iv;
    logic [u8rx_pkg::CNT_W-1:0] cnt_inc;
    logic                       level;
    logic                       accept;

    assign level   = s_tdata[0];
    assign accept  = s_tvalid & q_ready;
    assign ev_push = accept;

    always_comb begin
        full_iv = (bit_period_reg == '0) ? u8rx_pkg::CNT_W'(1) : bit_period_reg;
        half_iv = {1'b0, bit_period_reg[u8rx_pkg::CNT_W-1:1]};
        if (half_iv == '0) begin
            half_iv = u8rx_pkg::CNT_W'(1);
        end
        cnt_inc = cnt_reg + u8rx_pkg::CNT_W'(1);

        recv_next  = recv_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        tgt_next   = tgt_reg;
        ev.store   = 1'b0;
        ev.glitch  = 1'b0;

        if (recv_reg) begin
            if (cnt_inc >= tgt_reg) begin
                cnt_next = '0;
                if (bits_reg == 4'd0) begin
                    // middle of the start bit
                    if (level) begin
                        ev.glitch = 1'b1;
                        recv_next = 1'b0;
                    end else begin
                        bits_next = 4'd1;
                        tgt_next  = full_iv;
                    end
                end else begin
                    shift_next = {level, shift_reg[7:1]};
                    if (bits_reg >= u8rx_pkg::DATA_BITS) begin
                        // stop bit is not checked
                        ev.store  = 1'b1;
                        recv_next = 1'b0;
                        bits_next = 4'd0;
                    end else begin
                        bits_next = bits_reg + 4'd1;
                        tgt_next  = full_iv;
                    end
                end
                if (!recv_next) begin
                    bits_next = 4'd0;
                end
            end else begin
                cnt_next = cnt_inc;
            end
        end else if (prev_level_reg && !level) begin
            recv_next  = 1'b1;
            bits_next  = 4'd0;
            shift_next = '0;
            cnt_next   = '0;
            tgt_next   = half_iv;
        end
        prev_level_next = level;

        ev.pop_req = s_tdata[1];
        ev.data    = shift_next;
        ev.busy    = recv_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= u8rx_pkg::BIT_PERIOD_RESET;
        end else if (cfg_valid) begin
            bit_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            recv_reg       <= 1'b0;
            bits_reg       <= 4'd0;
            cnt_reg        <= '0;
            tgt_reg        <= '0;
        end else if (accept) begin
            prev_level_reg <= prev_level_next;
            recv_reg       <= recv_next;
            bits_reg       <= bits_next;
            cnt_reg        <= cnt_next;
            tgt_reg        <= tgt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== hdl/u8rx_queue.sv =====
module u8rx_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  u8rx_pkg::rx_event_t     push_data,
    output logic                    push_ready,
    input  logic                    pop,
    output logic                    pop_valid,
    output u8rx_pkg::rx_event_t     pop_data
);

    u8rx_pkg::rx_event_t q_reg [2];
    logic                wptr_reg;
    logic                rptr_reg;
    logic [1:0]          count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = q_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/u8rx_back.sv =====
module u8rx_back #(
    parameter int unsigned FIFO_DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ev_valid,
    input  u8rx_pkg::rx_event_t         ev,
    output logic                        ev_take,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [u8rx_pkg::OUT_W-1:0]  m_tdata
);

    localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FW = (PW + 1 > u8rx_pkg::FILL_W) ? PW + 1 : u8rx_pkg::FILL_W;
    localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);

    logic [7:0]                     fifo_mem_reg [FIFO_DEPTH];
    logic [PW-1:0]                  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]                  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                  wr_slot_next;
    logic [FW-1:0]                  fill;
    logic                           do_pop;
    logic                           do_write;
    logic                           drop;
    logic                           m_valid_reg;
    logic [7:0]                     rdata_reg;
    logic                           pvalid_reg;
    logic [u8rx_pkg::FILL_W-1:0]    fill_reg;
    logic                           busy_reg;
    logic                           glitch_reg;
    logic                           drop_reg;

    assign ev_take = ev_valid && (!m_valid_reg || m_tready);

    always_comb begin
        do_pop      = ev.pop_req && (rd_ptr_reg != wr_ptr_reg);
        rd_ptr_next = rd_ptr_reg;
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        wr_slot_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        // one slot stays free, so full is next write slot meeting the read side
        drop        = ev.store && (wr_slot_next == rd_ptr_next);
        do_write    = ev.store && !drop;
        wr_ptr_next = do_write ? wr_slot_next : wr_ptr_reg;
        if (wr_ptr_next >= rd_ptr_next) begin
            fill = FW'(wr_ptr_next) - FW'(rd_ptr_next);
        end else begin
            fill = FW'(wr_ptr_next) + FW'(FIFO_DEPTH) - FW'(rd_ptr_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ev_take) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
            end
            if (ev_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_take && do_write) begin
            fifo_mem_reg[wr_ptr_reg] <= ev.data;
        end
        if (ev_take && do_pop) begin
            rdata_reg <= fifo_mem_reg[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_take) begin
            pvalid_reg <= do_pop;
            fill_reg   <= fill[u8rx_pkg::FILL_W-1:0];
            busy_reg   <= ev.busy;
            glitch_reg <= ev.glitch;
            drop_reg   <= drop;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, drop_reg, glitch_reg, busy_reg, fill_reg, pvalid_reg,
                       pvalid_reg ? rdata_reg : 8'd0};

`ifndef SYNTHESIS
    a_ptr_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_ptr_reg <= LAST_SLOT) && (wr_ptr_reg <= LAST_SLOT))
        else $error("fifo pointer out of range");

    a_drop_holds_wr : assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_take && drop) |=> $stable(wr_ptr_reg))
        else $error("dropped word moved the write pointer");

    a_empty_pop : assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_take && ev.pop_req && (rd_ptr_reg == wr_ptr_reg)) |=> $stable(rd_ptr_reg))
        else $error("pop on empty fifo moved the read pointer");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(fill_reg)))
        else $error("stalled result changed");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int FIFO_SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic lvl;
        logic pop;
    } tick_word_t;

    typedef struct packed {
        logic [7:0]                  data;
        logic                        valid;
        logic [u8rx_pkg::FILL_W-1:0] fill;
        logic                        busy;
        logic                        glitch;
        logic                        dropped;
    } rx_result_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [u8rx_pkg::IN_W-1:0]   s_tdata = '0;     // [0] rx_level, [1] pop_req
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    // [7:0] pop_data, [8] pop_valid, [14:9] fill_count, [15] frame_busy,
    // [16] start_glitch, [17] byte_dropped
    logic [u8rx_pkg::OUT_W-1:0]  m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [u8rx_pkg::CNT_W-1:0]  cfg_data = '0;

    uart_8n1_receiver_with_fifo_core #(
        .FIFO_DEPTH(FIFO_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // receiver mirror
    logic [u8rx_pkg::CNT_W-1:0]  bit_period_q;
    logic                        last_lvl;
    logic                        in_frame;
    logic [3:0]                  bits_done;
    logic [7:0]                  rx_shift;
    logic [u8rx_pkg::CNT_W-1:0]  tick_cnt;
    logic [u8rx_pkg::CNT_W-1:0]  tick_goal;
    logic [7:0]                  fifo_mem [FIFO_SLOTS];
    logic [u8rx_pkg::FILL_W-1:0] wr_ptr;
    logic [u8rx_pkg::FILL_W-1:0] rd_ptr;

    rx_result_t        pending_results [$];
    rx_result_t        pred_r;
    rx_result_t        want_r;
    tick_word_t        tick_q [$];
    tick_word_t        next_w;

    int unsigned ticks_queued = 0;
    int unsigned ticks_in = 0;
    int unsigned cfg_count = 0;
    int unsigned words_checked = 0;
    int unsigned pops_seen = 0;
    int unsigned glitches_seen = 0;
    int unsigned drops_seen = 0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;

    logic        s_fire = 1'b0;
    bit          idle_on = 1'b1;
    int          s_gap = 0;
    int          m_gap = 0;
    int          hold_left = 0;
    int          pop_pct = 0;
    int          line_period = 729;

    function automatic logic [u8rx_pkg::CNT_W-1:0] full_ticks();
        return (bit_period_q == '0) ? 16'd1 : bit_period_q;
    endfunction

    task automatic receive_tick(input logic lvl, input logic pop, output rx_result_t r);
        logic [u8rx_pkg::FILL_W-1:0] nxt;
        r = '0;
        // a pop is served ahead of a store in the same tick
        if (pop && rd_ptr != wr_ptr) begin
            r.data = fifo_mem[rd_ptr];
            r.valid = 1'b1;
            rd_ptr = rd_ptr + 1'b1;
        end
        if (in_frame) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= tick_goal) begin
                tick_cnt = '0;
                if (bits_done == 4'd0) begin
                    if (lvl) begin
                        r.glitch = 1'b1;
                        in_frame = 1'b0;
                    end else begin
                        bits_done = 4'd1;
                        tick_goal = full_ticks();
                    end
                end else begin
                    rx_shift = {lvl, rx_shift[7:1]};
                    if (bits_done >= u8rx_pkg::DATA_BITS) begin
                        nxt = wr_ptr + 1'b1;
                        if (nxt == rd_ptr) begin
                            r.dropped = 1'b1;
                        end else begin
                            fifo_mem[wr_ptr] = rx_shift;
                            wr_ptr = nxt;
                        end
                        in_frame = 1'b0;
                    end else begin
                        bits_done = bits_done + 1'b1;
                        tick_goal = full_ticks();
                    end
                end
                if (!in_frame) bits_done = 4'd0;
            end
        end else if (last_lvl && !lvl) begin
            in_frame = 1'b1;
            bits_done = 4'd0;
            rx_shift = '0;
            tick_cnt = '0;
            tick_goal = (bit_period_q[u8rx_pkg::CNT_W-1:1] == '0) ? 16'd1 :
                        {1'b0, bit_period_q[u8rx_pkg::CNT_W-1:1]};
        end
        last_lvl = lvl;
        r.fill = wr_ptr - rd_ptr;
        r.busy = in_frame;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // sampling side: prediction on accepted tick words, checks on accepted results
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            bit_period_q = u8rx_pkg::BIT_PERIOD_RESET;
            last_lvl = 1'b1;
            in_frame = 1'b0;
            bits_done = '0;
            rx_shift = '0;
            tick_cnt = '0;
            tick_goal = '0;
            wr_ptr = '0;
            rd_ptr = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                receive_tick(s_tdata[0], s_tdata[1], pred_r);
                pending_results.push_back(pred_r);
                ticks_in++;
            end
            if (cfg_valid && cfg_ready) begin
                bit_period_q = cfg_data;
                cfg_count++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("word with no tick pending", 32'(m_tdata), 32'd0);
                end else begin
                    want_r = pending_results.pop_front();
                    if (m_tdata[7:0] != want_r.data)
                        report_mismatch("pop_data", 32'(m_tdata[7:0]), 32'(want_r.data));
                    if (m_tdata[8] != want_r.valid)
                        report_mismatch("pop_valid", 32'(m_tdata[8]), 32'(want_r.valid));
                    if (m_tdata[14:9] != want_r.fill)
                        report_mismatch("fill_count", 32'(m_tdata[14:9]), 32'(want_r.fill));
                    if (m_tdata[15] != want_r.busy)
                        report_mismatch("frame_busy", 32'(m_tdata[15]), 32'(want_r.busy));
                    if (m_tdata[16] != want_r.glitch)
                        report_mismatch("start_glitch", 32'(m_tdata[16]),
                                        32'(want_r.glitch));
                    if (m_tdata[17] != want_r.dropped)
                        report_mismatch("byte_dropped", 32'(m_tdata[17]),
                                        32'(want_r.dropped));
                    if (m_tdata[u8rx_pkg::OUT_W-1:18] != '0)
                        report_mismatch("padding", 32'(m_tdata[u8rx_pkg::OUT_W-1:18]), 32'd0);
                    words_checked++;
                    if (want_r.valid) pops_seen++;
                    if (want_r.glitch) glitches_seen++;
                    if (want_r.dropped) drops_seen++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // tick word driver
    always @(negedge aclk) begin
        if (!s_tvalid || s_fire) begin
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                next_w = tick_q.pop_front();
                s_tdata <= {{(u8rx_pkg::IN_W-2){1'b0}}, next_w.pop, next_w.lvl};
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 19) == 0) s_gap = $urandom_range(1, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap = m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 15) == 0) m_gap = $urandom_range(1, 14);
        end
    end

    task automatic push_tick(input logic lvl, input logic pop);
        tick_word_t w;
        w.lvl = lvl;
        w.pop = pop;
        tick_q.push_back(w);
        ticks_queued++;
    endtask

    task automatic push_level(input logic lvl);
        push_tick(lvl, $urandom_range(0, 99) < pop_pct);
    endtask

    // start bit, eight data bits lsb first, then a stop stretch; each bit ends on its sample tick
    task automatic push_frame(input logic [7:0] b, input int p, input bit glitch, input int stop);
        int half;
        half = p / 2;
        push_level(1'b0);
        for (int i = 1; i < half; i++) push_level(1'b0);
        if (glitch) begin
            push_level(1'b1);
        end else begin
            push_level(1'b0);
            for (int k = 0; k < 8; k++)
                for (int j = 0; j < p; j++) push_level(b[k]);
        end
        for (int i = 0; i < stop; i++) push_level(1'b1);
    endtask

    task automatic random_frames(input int count);
        push_level(1'b1);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) push_level(1'($urandom_range(0, 1)));
            push_frame(8'($urandom_range(0, 255)), line_period, $urandom_range(0, 7) == 0,
                       $urandom_range(0, 2));
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (ticks_in != ticks_queued || pending_results.size() != 0);
    endtask

    task automatic write_period(input logic [u8rx_pkg::CNT_W-1:0] v);
        int unsigned n;
        wait_drained();
        n = cfg_count;
        cfg_valid <= 1'b1;
        cfg_data <= v;
        while (cfg_count == n) @(negedge aclk);
        cfg_valid <= 1'b0;
        line_period = int'(v);
    endtask

    initial begin
        logic [7:0] lb;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // start glitch at the power-up bit period, then a pop on the empty fifo
        pop_pct = 0;
        push_level(1'b1);
        push_frame(8'h00, int'(u8rx_pkg::BIT_PERIOD_RESET), 1'b1, 1);
        push_tick(1'b1, 1'b1);

        // period 2: empty pop, start glitch, edges inside a frame, end-of-frame tick
        write_period(16'd2);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        lb = 8'h5a;
        for (int k = 0; k < 7; k++) begin
            push_tick(lb[k], 1'b0);
            push_tick(lb[k], 1'b0);
        end
        // d7 falls on its sample tick, and the pop there sees an empty fifo
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);

        // tiny period, frames back to back to overfill the fifo, the output side stalled at the start
        write_period(16'd1);
        hold_left = HOLD_OFF_CYCLES;
        push_level(1'b1);
        repeat (65) push_frame(8'($urandom_range(0, 255)) | 8'h80, 1, 1'b0, 0);

        // drain it again over a few periods
        wait_drained();
        pop_pct = 80;
        write_period(16'd3);
        random_frames(2);
        write_period(16'($urandom_range(4, 6)));
        random_frames(1);
        repeat (20) push_level(1'b1);

        // period switched to a short one in mid-frame after the start check
        write_period(16'd8);
        pop_pct = 1;
        lb = 8'($urandom_range(0, 255));
        push_level(1'b1);
        push_level(1'b0);
        repeat (4) push_level(1'b0);
        write_period(16'd3);
        repeat (8) push_level(lb[0]);
        for (int k = 1; k < 8; k++) repeat (3) push_level(lb[k]);
        push_level(1'b1);
        push_tick(1'b1, 1'b1);

        // closing stretch without idling
        wait_drained();
        idle_on = 1'b0;
        write_period(16'($urandom_range(2, 4)));
        pop_pct = 40;
        random_frames(2);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 32'(pending_results.size()), 32'd0);
        $display("covered %0d tick words: %0d bytes popped, %0d start glitches, %0d bytes dropped",
                 words_checked, pops_seen, glitches_seen, drops_seen);
        $display("bit periods 1 to 729, a mid-frame period change, a full fifo under stall");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
